// ----- rtl/code128_set_b_symbol_encoder_defines.svh -----
// ---------------------------------------------------------------------------
// Code 128 set B encoder assertion macros
// Concurrent checks on the encoder clock and reset, removable at compile time.
// ---------------------------------------------------------------------------
`ifndef CODE128_SET_B_SYMBOL_ENCODER_DEFINES_SVH
`define CODE128_SET_B_SYMBOL_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define C128B_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define C128B_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define C128B_ASSERT(name, cond, msg)
`define C128B_ASSERT_IMPL(name, ante, cons, msg)
`endif

`endif

// ----- rtl/c128b_pkg.sv -----
// ---------------------------------------------------------------------------
// Code 128 set B encoder package
// Symbol constants, element width table and beat packing.
// ---------------------------------------------------------------------------
package c128b_pkg;

  localparam logic [6:0]  SYM_MOD     = 7'd103;
  localparam logic [6:0]  SYM_START_B = 7'd104;
  localparam logic [6:0]  SYM_STOP    = 7'd106;
  localparam logic [6:0]  WEIGHT_MAX  = 7'd102;
  localparam logic [7:0]  CHAR_LOW    = 8'h20;
  localparam logic [7:0]  CHAR_HIGH   = 8'h7E;
  localparam logic [23:0] STOP_PAT    = 24'h233111;
  localparam logic [1:0]  STOP_W7     = 2'd2;
  localparam logic [13:0] MOD_RECIP   = 14'd10181;  // ceil(2^20 / 103)
  localparam int          RECIP_SHIFT = 20;
  localparam int          NUM_SYMS    = 106;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CHK,
    PH_STOP
  } phase_e;

  // Element widths, one hex digit per element, bar first.
  localparam logic [23:0] SYM_PAT [NUM_SYMS] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
    24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
    24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
    24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
    24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
    24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
    24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
    24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
    24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
    24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
    24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
    24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
    24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
    24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
    24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
    24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
    24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
    24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
    24'h211232
  };

  function automatic logic [31:0] make_symbol(input logic [6:0] value);
    logic [23:0] pat;
    logic [1:0]  w7;
    pat = '0;
    w7  = '0;
    if (value == SYM_STOP) begin
      pat = STOP_PAT;
      w7  = STOP_W7;
    end else if (value < 7'(NUM_SYMS)) begin
      pat = SYM_PAT[value];
    end
    return {5'd0, w7, pat[2:0], pat[6:4], pat[10:8], pat[14:12],
            pat[18:16], pat[22:20], value};
  endfunction

endpackage

// ----- rtl/code128_set_b_symbol_encoder.sv -----
// ---------------------------------------------------------------------------
// Code 128 set B symbol encoder
// Turns text bytes into start, data, checksum and stop symbols with their
// element widths; reports an invalid byte once and drops the rest of the text.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                              tuser    tlast
//  s_axis   in   char_code[7:0]                     -        last_char
//  m_axis   out  symbol_value, width_1..7 (32 bit)  status   last_symbol
//
//  A data byte yields its symbol; the first byte of a text is preceded by
//  the start symbol. The last byte adds the checksum and stop symbols, and the
//  checksum waits for the three-stage modulo-103 product pipeline to drain.
//  Asynchronous active-low reset, no clearing pass.
//  A stalled output holds one beat while one more byte waits in the input reg.
// ---------------------------------------------------------------------------
`include "code128_set_b_symbol_encoder_defines.svh"

module code128_set_b_symbol_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [6:0] symbol_value, [9:7] width_1,
                                      // [12:10] width_2, [15:13] width_3,
                                      // [18:16] width_4, [21:19] width_5,
                                      // [24:22] width_6, [26:25] width_7
  output logic        m_axis_tuser,   // [0] status
  output logic        m_axis_tlast
);
  import c128b_pkg::*;

  logic        it_valid_q, it_valid_d;
  logic [7:0]  it_char_q;
  logic        it_last_q;
  phase_e      ph_q, ph_d;
  logic        in_progress_q, in_progress_d;
  logic        discarding_q, discarding_d;
  logic [6:0]  sum_q, sum_d;
  logic [6:0]  weight_q, weight_d;

  logic        m_valid_q, m_valid_d;
  logic [31:0] m_data_q, m_data_d;
  logic        m_user_q, m_user_d;
  logic        m_last_q, m_last_d;

  logic        pv1_q, pv2_q, pv3_q;
  logic [13:0] p1_q, p2_q;
  logic [6:0]  q2_q, pm3_q;
  logic [27:0] recip_prod;
  logic [13:0] q_times_mod;
  logic [13:0] rem14;
  logic [7:0]  sum_add;
  logic [6:0]  sum_acc;

  logic        out_free, emit, item_done, launch, kill, pipe_busy, bad_char;
  logic [6:0]  char_val;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign pipe_busy = pv1_q || pv2_q || pv3_q;
  assign bad_char  = (it_char_q < CHAR_LOW) || (it_char_q > CHAR_HIGH);
  assign char_val  = 7'(it_char_q - CHAR_LOW);

  assign recip_prod  = 28'(p1_q) * 28'(MOD_RECIP);
  assign q_times_mod = 14'(q2_q) * 14'(SYM_MOD);
  assign rem14       = p2_q - q_times_mod;
  assign sum_add     = {1'b0, sum_q} + {1'b0, pm3_q};
  assign sum_acc     = (sum_add >= {1'b0, SYM_MOD}) ? 7'(sum_add - {1'b0, SYM_MOD})
                                                    : sum_add[6:0];

  always_comb begin
    ph_d          = ph_q;
    in_progress_d = in_progress_q;
    discarding_d  = discarding_q;
    sum_d         = pv3_q ? sum_acc : sum_q;
    weight_d      = weight_q;
    emit          = 1'b0;
    item_done     = 1'b0;
    launch        = 1'b0;
    kill          = 1'b0;
    m_data_d      = m_data_q;
    m_user_d      = m_user_q;
    m_last_d      = m_last_q;
    if (it_valid_q) begin
      if (discarding_q) begin
        item_done = 1'b1;
        if (it_last_q) begin
          discarding_d  = 1'b0;
          in_progress_d = 1'b0;
        end
      end else begin
        case (ph_q)
          PH_DATA: begin
            if (out_free) begin
              emit     = 1'b1;
              m_user_d = 1'b0;
              m_last_d = 1'b0;
              if (!in_progress_q) begin
                m_data_d      = make_symbol(SYM_START_B);
                in_progress_d = 1'b1;
                sum_d         = 7'd1;
                weight_d      = 7'd1;
                kill          = 1'b1;
              end else if (bad_char) begin
                m_data_d      = '0;
                m_user_d      = 1'b1;
                m_last_d      = 1'b1;
                in_progress_d = 1'b0;
                discarding_d  = !it_last_q;
                item_done     = 1'b1;
              end else begin
                m_data_d = make_symbol(char_val);
                launch   = 1'b1;
                weight_d = (weight_q == WEIGHT_MAX) ? 7'd0 : 7'(weight_q + 7'd1);
                if (it_last_q) begin
                  ph_d = PH_CHK;
                end else begin
                  item_done = 1'b1;
                end
              end
            end
          end
          PH_CHK: begin
            if (out_free && !pipe_busy) begin
              emit     = 1'b1;
              m_data_d = make_symbol(sum_q);
              m_user_d = 1'b0;
              m_last_d = 1'b0;
              ph_d     = PH_STOP;
            end
          end
          PH_STOP: begin
            if (out_free) begin
              emit          = 1'b1;
              m_data_d      = make_symbol(SYM_STOP);
              m_user_d      = 1'b0;
              m_last_d      = 1'b1;
              in_progress_d = 1'b0;
              sum_d         = '0;
              weight_d      = '0;
              item_done     = 1'b1;
            end
          end
          default: begin
            ph_d = PH_DATA;
          end
        endcase
      end
    end
    if (item_done) begin
      ph_d = PH_DATA;
    end
  end

  assign s_axis_tready = !it_valid_q || item_done;
  assign it_valid_d    = (s_axis_tvalid && s_axis_tready) || (it_valid_q && !item_done);
  assign m_valid_d     = emit || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_valid_q    <= 1'b0;
      ph_q          <= PH_DATA;
      in_progress_q <= 1'b0;
      discarding_q  <= 1'b0;
      sum_q         <= '0;
      weight_q      <= '0;
      m_valid_q     <= 1'b0;
      pv1_q         <= 1'b0;
      pv2_q         <= 1'b0;
      pv3_q         <= 1'b0;
    end else begin
      it_valid_q    <= it_valid_d;
      ph_q          <= ph_d;
      in_progress_q <= in_progress_d;
      discarding_q  <= discarding_d;
      sum_q         <= sum_d;
      weight_q      <= weight_d;
      m_valid_q     <= m_valid_d;
      pv1_q         <= launch;
      pv2_q         <= pv1_q && !kill;
      pv3_q         <= pv2_q && !kill;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      it_char_q <= s_axis_tdata;
      it_last_q <= s_axis_tlast;
    end
    if (emit) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
      m_last_q <= m_last_d;
    end
    if (launch) begin
      p1_q <= 14'(weight_q) * 14'(char_val);
    end
    p2_q  <= p1_q;
    q2_q  <= recip_prod[RECIP_SHIFT +: 7];
    pm3_q <= rem14[6:0];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  `C128B_ASSERT(a_sum_reduced, sum_q < SYM_MOD, "checksum residue out of range")
  `C128B_ASSERT(a_weight_reduced, weight_q < SYM_MOD, "weight residue out of range")
  `C128B_ASSERT_IMPL(a_chk_drained, emit && ph_q == PH_CHK, !pipe_busy,
                     "checksum sent before product pipeline drained")
  `C128B_ASSERT_IMPL(a_discard_idle, discarding_q, !in_progress_q,
                     "discarding while a text is in progress")

endmodule
